// ===== rtl/segt_pkg.sv =====
// Shared types and constants for the segment tree point-set / range-sum block.
// Used by segt_node_mem, segt_seq and segment_tree_point_set_range_sum.
package segt_pkg;

    localparam int POS_W          = 11;
    localparam int VAL_W          = 32;
    localparam int SUM_W          = 42;
    localparam int SIZE_RESET     = 1024;
    localparam int DEF_MAX_LEAVES = 1024;

    localparam logic REQ_SET   = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_OUT_RANGE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_SET_DOWN,
        S_SET_LEAF,
        S_SET_UP,
        S_PRE,
        S_DRAIN,
        S_OUT
    } t_seq_state;

    // Top level to sequencer.
    typedef struct packed {
        logic start;
        logic clear;
        logic out_free;
    } t_seq_ctrl;

    // Sequencer to top level.
    typedef struct packed {
        logic                    busy;
        logic                    done;
        logic                    status;
        logic signed [SUM_W-1:0] range_sum;
    } t_seq_stat;

endpackage

// ===== rtl/segt_node_mem.sv =====
// Node sum store: one write port and one read port with registered read data.
// Depends on segt_pkg for the sum width.
module segt_node_mem #(
    parameter int DEPTH = 4 * segt_pkg::DEF_MAX_LEAVES,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                             i_clk,
    input  logic                             i_wr_en,
    input  logic [AW-1:0]                    i_wr_addr,
    input  logic signed [segt_pkg::SUM_W-1:0] i_wr_data,
    input  logic                             i_rd_en,
    input  logic [AW-1:0]                    i_rd_addr,
    output logic signed [segt_pkg::SUM_W-1:0] o_rd_data
);
    import segt_pkg::*;

    logic signed [SUM_W-1:0] r_nodes [DEPTH];
    logic signed [SUM_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_nodes[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_nodes[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/segt_seq.sv =====
// Sequencer and shared add/subtract unit that walks the segment tree one level per step.
// Depends on segt_pkg; drives the node store ports of segt_node_mem.
module segt_seq #(
    parameter int MAX_LEAVES = segt_pkg::DEF_MAX_LEAVES,
    parameter int DEPTH      = 4 * MAX_LEAVES,
    parameter int AW         = $clog2(DEPTH)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  segt_pkg::t_seq_ctrl               i_ctrl,
    output segt_pkg::t_seq_stat               o_stat,
    input  logic [segt_pkg::POS_W-1:0]        i_size,
    input  logic                              i_req_type,
    input  logic [segt_pkg::POS_W-1:0]        i_position_low,
    input  logic [segt_pkg::POS_W-1:0]        i_position_high,
    input  logic signed [segt_pkg::VAL_W-1:0] i_new_value,
    output logic                              o_wr_en,
    output logic [AW-1:0]                     o_wr_addr,
    output logic signed [segt_pkg::SUM_W-1:0] o_wr_data,
    output logic                              o_rd_en,
    output logic [AW-1:0]                     o_rd_addr,
    input  logic signed [segt_pkg::SUM_W-1:0] i_rd_data
);
    import segt_pkg::*;

    localparam logic [AW-1:0] ROOT     = AW'(1);
    localparam logic [AW-1:0] LAST_ROW = AW'(DEPTH - 1);

    t_seq_state              r_state, n_state;
    logic [AW-1:0]           r_k, n_k;
    logic [AW-1:0]           r_clr, n_clr;
    logic [POS_W-1:0]        r_lo, n_lo;
    logic [POS_W-1:0]        r_hi, n_hi;
    logic [POS_W-1:0]        r_x, n_x;
    logic [POS_W-1:0]        r_x2, n_x2;
    logic                    r_second, n_second;
    logic signed [SUM_W-1:0] r_acc, n_acc;
    logic                    r_pend, n_pend;
    logic                    r_pend_sub, n_pend_sub;
    logic signed [VAL_W-1:0] r_value, n_value;
    logic                    r_is_query, n_is_query;
    logic                    r_status, n_status;

    logic [POS_W:0]          w_mid_sum;
    logic [POS_W-1:0]        w_mid;
    logic [AW-1:0]           w_left;
    logic [AW-1:0]           w_right;
    logic [AW-1:0]           w_parent;
    logic [POS_W-1:0]        w_qlo;
    logic [POS_W-1:0]        w_qhi;
    logic signed [SUM_W-1:0] w_alu;

    assign w_mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid     = w_mid_sum[POS_W:1];
    assign w_left    = {r_k[AW-2:0], 1'b0};
    assign w_right   = {r_k[AW-2:0], 1'b1};
    assign w_parent  = {1'b0, r_k[AW-1:1]};
    assign w_qlo     = (i_position_low == '0) ? POS_W'(1) : i_position_low;
    assign w_qhi     = (i_position_high > i_size) ? i_size : i_position_high;

    // The one arithmetic unit: accumulates read sums, or subtracts the lower prefix.
    assign w_alu = r_pend_sub ? (r_acc - i_rd_data) : (r_acc + i_rd_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k        <= n_k;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_x        <= n_x;
        r_x2       <= n_x2;
        r_second   <= n_second;
        r_acc      <= n_acc;
        r_pend_sub <= n_pend_sub;
        r_value    <= n_value;
        r_is_query <= n_is_query;
        r_status   <= n_status;
    end

    always_comb begin
        n_state    = r_state;
        n_k        = r_k;
        n_clr      = r_clr;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_x        = r_x;
        n_x2       = r_x2;
        n_second   = r_second;
        n_acc      = r_pend ? w_alu : r_acc;
        n_pend     = 1'b0;
        n_pend_sub = 1'b0;
        n_value    = r_value;
        n_is_query = r_is_query;
        n_status   = r_status;
        o_wr_en    = 1'b0;
        o_wr_addr  = r_k;
        o_wr_data  = w_alu;
        o_rd_en    = 1'b0;
        o_rd_addr  = r_k;

        unique case (r_state)
            S_IDLE: begin
                if (i_ctrl.start) begin
                    n_lo       = POS_W'(1);
                    n_hi       = i_size;
                    n_k        = ROOT;
                    n_acc      = '0;
                    n_is_query = i_req_type;
                    n_status   = STATUS_OK;
                    n_second   = 1'b0;
                    if (i_req_type == REQ_SET) begin
                        if (i_position_low == '0 || i_position_low > i_size) begin
                            n_status = STATUS_OUT_RANGE;
                            n_state  = S_OUT;
                        end else begin
                            n_x     = i_position_low;
                            n_value = i_new_value;
                            n_state = S_SET_DOWN;
                        end
                    end else begin
                        // The range sum is prefix(high) minus prefix(low - 1).
                        if (w_qlo > w_qhi) begin
                            n_state = S_OUT;
                        end else begin
                            n_x     = w_qhi;
                            n_x2    = w_qlo - POS_W'(1);
                            n_state = S_PRE;
                        end
                    end
                end
            end
            S_CLEAR: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_clr;
                o_wr_data = '0;
                if (r_clr == LAST_ROW) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + AW'(1);
                end
            end
            S_SET_DOWN: begin
                if (r_lo == r_hi) begin
                    n_state = S_SET_LEAF;
                end else if (r_x <= w_mid) begin
                    n_k  = w_left;
                    n_hi = w_mid;
                end else begin
                    n_k  = w_right;
                    n_lo = w_mid + POS_W'(1);
                end
            end
            S_SET_LEAF: begin
                o_wr_en   = 1'b1;
                o_wr_data = SUM_W'(r_value);
                n_acc     = SUM_W'(r_value);
                if (r_k == ROOT) begin
                    n_state = S_OUT;
                end else begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = r_k ^ AW'(1);
                    n_pend    = 1'b1;
                    n_state   = S_SET_UP;
                end
            end
            S_SET_UP: begin
                // The sibling read last cycle is here; write the parent and fetch
                // the parent's sibling in the same cycle.
                o_wr_en   = 1'b1;
                o_wr_addr = w_parent;
                if (w_parent == ROOT) begin
                    n_state = S_OUT;
                end else begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = w_parent ^ AW'(1);
                    n_k       = w_parent;
                    n_pend    = 1'b1;
                end
            end
            S_PRE: begin
                if (r_x >= r_hi) begin
                    o_rd_en    = 1'b1;
                    n_pend     = 1'b1;
                    n_pend_sub = r_second;
                    if (r_second || r_x2 == '0) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_second = 1'b1;
                        n_x      = r_x2;
                        n_lo     = POS_W'(1);
                        n_hi     = i_size;
                        n_k      = ROOT;
                    end
                end else if (r_x <= w_mid) begin
                    n_k  = w_left;
                    n_hi = w_mid;
                end else begin
                    // The whole left child lies inside the prefix.
                    o_rd_en    = 1'b1;
                    o_rd_addr  = w_left;
                    n_pend     = 1'b1;
                    n_pend_sub = r_second;
                    n_k        = w_right;
                    n_lo       = w_mid + POS_W'(1);
                end
            end
            S_DRAIN: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_ctrl.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_ctrl.clear) begin
            n_state = S_CLEAR;
            n_clr   = '0;
            n_pend  = 1'b0;
        end
    end

    assign o_stat.busy      = (r_state != S_IDLE);
    assign o_stat.done      = (r_state == S_OUT);
    assign o_stat.status    = r_status;
    assign o_stat.range_sum = r_is_query ? r_acc : '0;

endmodule

// ===== rtl/segment_tree_point_set_range_sum.sv =====
// Segment tree with point set and inclusive range-sum query over positions 1..size.
// With D = ceil(log2(size)), a set walks down at most D levels without memory traffic, writes
// the leaf and then rewrites one ancestor per cycle. A query is computed as prefix(high) minus
// prefix(low-1), each prefix one tree level per cycle through the single read port of the node
// store; clipped-empty ranges and out-of-range sets skip the tree walk. When the output
// register is still full and stalled, the finished request waits for it. After reset and after
// every size write the node store is cleared one entry per cycle, all 4*MAX_LEAVES entries,
// while input is stalled. A finished result sits in an output register, so the next request
// can be taken while it waits. The size register may be written only while the block is idle.
module segment_tree_point_set_range_sum #(
    parameter int MAX_LEAVES = segt_pkg::DEF_MAX_LEAVES
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [segt_pkg::POS_W-1:0]        i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_req_type,
    input  logic [segt_pkg::POS_W-1:0]        i_position_low,
    input  logic [segt_pkg::POS_W-1:0]        i_position_high,
    input  logic signed [segt_pkg::VAL_W-1:0] i_new_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [segt_pkg::SUM_W-1:0] o_range_sum,
    output logic                              o_status
);
    import segt_pkg::*;

    localparam int DEPTH = 4 * MAX_LEAVES;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [POS_W-1:0] SIZE_INIT =
        POS_W'((MAX_LEAVES < SIZE_RESET) ? MAX_LEAVES : SIZE_RESET);

    logic [POS_W-1:0]        r_size, n_size;
    logic                    r_out_valid;
    logic signed [SUM_W-1:0] r_range_sum;
    logic                    r_status;

    t_seq_ctrl               w_ctrl;
    t_seq_stat               w_stat;
    logic                    w_cfg_xfer;
    logic                    w_in_xfer;
    logic                    w_load;
    logic                    w_wr_en;
    logic [AW-1:0]           w_wr_addr;
    logic signed [SUM_W-1:0] w_wr_data;
    logic                    w_rd_en;
    logic [AW-1:0]           w_rd_addr;
    logic signed [SUM_W-1:0] w_rd_data;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_xfer  = i_cfg_valid && o_cfg_ready;
    assign o_in_stall  = w_stat.busy;
    assign w_in_xfer   = i_in_valid && !o_in_stall;

    always_comb begin
        priority if (i_cfg_data == '0) begin
            n_size = POS_W'(1);
        end else if (32'(i_cfg_data) > 32'(MAX_LEAVES)) begin
            n_size = POS_W'(MAX_LEAVES);
        end else begin
            n_size = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_INIT;
        end else if (w_cfg_xfer) begin
            r_size <= n_size;
        end
    end

    assign w_ctrl.start    = w_in_xfer;
    assign w_ctrl.clear    = w_cfg_xfer;
    assign w_ctrl.out_free = !r_out_valid || !i_out_stall;
    assign w_load          = w_stat.done && w_ctrl.out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_range_sum <= w_stat.range_sum;
            r_status    <= w_stat.status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_range_sum = r_range_sum;
    assign o_status    = r_status;

    segt_seq #(
        .MAX_LEAVES (MAX_LEAVES),
        .DEPTH      (DEPTH),
        .AW         (AW)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (w_ctrl),
        .o_stat          (w_stat),
        .i_size          (r_size),
        .i_req_type      (i_req_type),
        .i_position_low  (i_position_low),
        .i_position_high (i_position_high),
        .i_new_value     (i_new_value),
        .o_wr_en         (w_wr_en),
        .o_wr_addr       (w_wr_addr),
        .o_wr_data       (w_wr_data),
        .o_rd_en         (w_rd_en),
        .o_rd_addr       (w_rd_addr),
        .i_rd_data       (w_rd_data)
    );

    segt_node_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

`ifndef SYNTH
    // Every request transfer stalls the input in the cycle after it.
    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> o_in_stall)
        else $error("input not stalled after a request transfer");

    // A size write always starts a clearing pass.
    a_clear_after_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_xfer |=> o_in_stall)
        else $error("input not stalled after a size write");

    // A rejected set never reports a sum.
    a_status_sum_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status) |-> (o_range_sum == '0))
        else $error("nonzero sum with out-of-range status");

    // A result is loaded only into a free output register.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_range_sum)))
        else $error("pending result overwritten");
`endif

endmodule
